// ===== rtl/mprc_pkg.sv =====
// ----------------------------------------------------------------------------
// mprc_pkg
// Types and codes shared by the position ramp controller and its divider.
// ----------------------------------------------------------------------------
`default_nettype none

package mprc_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_PRESET_TARGET = 3'd0;
    localparam logic [2:0] CFG_START_MARGIN  = 3'd1;
    localparam logic [2:0] CFG_STOP_MARGIN   = 3'd2;
    localparam logic [2:0] CFG_RAMP_SPAN     = 3'd3;
    localparam logic [2:0] CFG_DUTY_OFFSET   = 3'd4;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 31;

    // Reset values of the configuration registers
    localparam logic [30:0] RST_PRESET_TARGET = 31'd197500;
    localparam logic [15:0] RST_START_MARGIN  = 16'd20;
    localparam logic [15:0] RST_STOP_MARGIN   = 16'd3;
    localparam logic [15:0] RST_RAMP_SPAN     = 16'd20000;
    localparam logic [15:0] RST_DUTY_OFFSET   = 16'd1000;

    typedef enum logic [1:0] {
        MODE_STOP  = 2'd0,
        MODE_ERROR = 2'd1,
        MODE_FWD   = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_POS,
        SEQ_DIST,
        SEQ_EVAL,
        SEQ_MUL,
        SEQ_DIV,
        SEQ_FIN
    } t_seq;

    typedef struct packed {
        logic [15:0] encoder_count;
        logic        counter_wrapped;
        logic        wrap_up;
        logic        front_switch_closed;
        logic        preset_request;
    } t_in_beat;

    typedef struct packed {
        logic [15:0]        duty;
        logic               direction;
        logic [1:0]         mode;
        logic signed [31:0] position;
    } t_out_beat;

    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [15:0] den;
    } t_div_req;

endpackage

`default_nettype wire

// ===== rtl/mprc_div.sv =====
// ----------------------------------------------------------------------------
// mprc_div
// Serial restoring divider, one quotient bit per cycle. The caller keeps
// num / den below 2^16, so sixteen steps give the whole quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module mprc_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mprc_pkg::t_div_req i_req,
    output logic                   o_done,
    output logic [15:0]            o_quo
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [3:0]  r_cnt, n_cnt;
    logic [15:0] r_rem, n_rem;
    logic [15:0] r_lo, n_lo;
    logic [15:0] r_quo, n_quo;
    logic [15:0] r_den, n_den;

    logic [16:0] w_trial;
    logic        w_ge;

    assign w_trial = {r_rem, r_lo[15]};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_lo   = r_lo;
        n_quo  = r_quo;
        n_den  = r_den;
        if (i_req.start) begin
            // upper half is already below the divisor
            n_busy = 1'b1;
            n_cnt  = 4'hF;
            n_rem  = i_req.num[31:16];
            n_lo   = i_req.num[15:0];
            n_den  = i_req.den;
        end else if (r_busy) begin
            n_rem = w_ge ? 16'(w_trial - {1'b0, r_den}) : w_trial[15:0];
            n_lo  = {r_lo[14:0], 1'b0};
            n_quo = {r_quo[14:0], w_ge};
            n_cnt = r_cnt - 4'd1;
            if (r_cnt == 4'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 4'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_lo  <= n_lo;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

    property p_no_start_while_busy;
        @(posedge i_clk) disable iff (!i_rst_n) r_busy |-> !i_req.start;
    endproperty
    a_no_start_while_busy: assert property (p_no_start_while_busy)
        else $error("divider restarted mid-division");

    property p_done_after_busy;
        @(posedge i_clk) disable iff (!i_rst_n) n_done |-> r_busy;
    endproperty
    a_done_after_busy: assert property (p_done_after_busy)
        else $error("divider done without a running division");

    property p_rem_below_den;
        @(posedge i_clk) disable iff (!i_rst_n) (r_busy && r_den != 16'd0) |-> (r_rem < r_den);
    endproperty
    a_rem_below_den: assert property (p_rem_below_den)
        else $error("divider remainder reached the divisor");

endmodule

`default_nettype wire

// ===== rtl/motor_position_ramp_controller.sv =====
// ----------------------------------------------------------------------------
// motor_position_ramp_controller
// Carriage position tracking with a proportional duty ramp toward a target.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes one beat per
//   control tick: encoder count, wrap flag and direction, front end switch,
//   preset request. Output channel (o_out_valid / i_out_stall / o_out_data)
//   returns one beat per tick: duty, direction, mode and 32-bit position.
//   Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data),
//   written only while no tick is in flight; the user must keep to this, as
//   the block does not enforce it. A tick steps through position, distance
//   and evaluation; one that ends in stop or error goes on to the final
//   step, which writes the output register; one that ramps duty in forwards
//   first waits on the 16-step serial divider that forms the proportional
//   term. The input reopens as the result is written.
//   One tick is in flight at a time; o_in_stall stays high until its result
//   sits in the output register.
//   The output register holds a result while the receiver stalls, and the
//   next tick may be accepted meanwhile; that tick waits at its last step
//   until the register frees.
//   Reset (synchronous, active low): configuration returns to its defaults,
//   wrap count and target clear, mode is stop, duty 0, direction forwards.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_position_ramp_controller #(
    parameter int FULL_DUTY = 65535
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire mprc_pkg::t_in_beat                 i_in_data,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output mprc_pkg::t_out_beat                     o_out_data,
    input  wire logic                               i_cfg_we,
    input  wire logic [mprc_pkg::CfgIdxW-1:0]       i_cfg_idx,
    input  wire logic [mprc_pkg::CfgDataW-1:0]      i_cfg_data
);

    localparam logic [15:0] FullDuty = 16'(FULL_DUTY);

    // configuration
    logic [30:0] r_preset;
    logic [15:0] r_start_m, r_stop_m, r_span, r_offset;

    // control state
    mprc_pkg::t_seq  r_state, n_state;
    mprc_pkg::t_mode r_mode, n_mode;
    logic [15:0]     r_wrap, n_wrap;
    logic [31:0]     r_target, n_target;
    logic [15:0]     r_duty, n_duty;
    logic            r_dir, n_dir;
    logic            r_out_valid, n_out_valid;

    // payload
    mprc_pkg::t_in_beat  r_in;
    mprc_pkg::t_out_beat r_out, n_out;
    logic signed [31:0]  r_pos, n_pos;
    logic [33:0]         r_dist, n_dist;
    logic [15:0]         r_lim, n_lim;

    logic              w_in_acc, w_out_free;
    logic              w_go_fwd, w_halt, w_dist_lt_span;
    logic [15:0]       w_span;
    logic [16:0]       w_duty_sum;
    mprc_pkg::t_div_req w_div_req;
    logic              w_div_done;
    logic [15:0]       w_div_quo;

    assign o_in_stall = (r_state != mprc_pkg::SEQ_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_span         = (r_span == 16'd0) ? 16'd1 : r_span;
    assign w_go_fwd       = $signed(r_dist) > $signed({18'd0, r_start_m});
    assign w_halt         = r_dist[33] || (r_dist < {18'd0, r_stop_m});
    assign w_dist_lt_span = r_dist < {18'd0, w_span};
    assign w_duty_sum     = {1'b0, w_div_quo} + {1'b0, r_offset};

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preset  <= mprc_pkg::RST_PRESET_TARGET;
            r_start_m <= mprc_pkg::RST_START_MARGIN;
            r_stop_m  <= mprc_pkg::RST_STOP_MARGIN;
            r_span    <= mprc_pkg::RST_RAMP_SPAN;
            r_offset  <= mprc_pkg::RST_DUTY_OFFSET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mprc_pkg::CFG_PRESET_TARGET: r_preset  <= i_cfg_data;
                mprc_pkg::CFG_START_MARGIN:  r_start_m <= i_cfg_data[15:0];
                mprc_pkg::CFG_STOP_MARGIN:   r_stop_m  <= i_cfg_data[15:0];
                mprc_pkg::CFG_RAMP_SPAN:     r_span    <= i_cfg_data[15:0];
                mprc_pkg::CFG_DUTY_OFFSET:   r_offset  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mprc_pkg::SEQ_IDLE: if (w_in_acc) n_state = mprc_pkg::SEQ_POS;
            mprc_pkg::SEQ_POS:  n_state = mprc_pkg::SEQ_DIST;
            mprc_pkg::SEQ_DIST: n_state = mprc_pkg::SEQ_EVAL;
            mprc_pkg::SEQ_EVAL: begin
                if (r_mode == mprc_pkg::MODE_FWD && !w_halt) begin
                    n_state = mprc_pkg::SEQ_MUL;
                end else begin
                    n_state = mprc_pkg::SEQ_FIN;
                end
            end
            mprc_pkg::SEQ_MUL:  n_state = mprc_pkg::SEQ_DIV;
            mprc_pkg::SEQ_DIV:  if (w_div_done) n_state = mprc_pkg::SEQ_FIN;
            mprc_pkg::SEQ_FIN:  if (w_out_free) n_state = mprc_pkg::SEQ_IDLE;
            default:            n_state = mprc_pkg::SEQ_IDLE;
        endcase
    end

    // sequencer actions
    always_comb begin
        n_mode      = r_mode;
        n_wrap      = r_wrap;
        n_target    = r_target;
        n_duty      = r_duty;
        n_dir       = r_dir;
        n_pos       = r_pos;
        n_dist      = r_dist;
        n_lim       = r_lim;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        w_div_req   = '{start: 1'b0, num: 32'd0, den: w_span};
        case (r_state)
            mprc_pkg::SEQ_POS: begin
                if (r_in.preset_request) n_target = {1'b0, r_preset};
                if (r_in.front_switch_closed) begin
                    n_mode = mprc_pkg::MODE_ERROR;
                    n_duty = 16'd0;
                end
                if (r_in.counter_wrapped) begin
                    n_wrap = r_in.wrap_up ? r_wrap + 16'd1 : r_wrap - 16'd1;
                end
                // wraps * 65535 + count, done as wraps * 65536 - wraps + count
                n_pos = $signed({n_wrap, 16'h0000} - {{16{n_wrap[15]}}, n_wrap}
                                + {16'h0000, r_in.encoder_count});
            end
            mprc_pkg::SEQ_DIST: begin
                n_dist = {{2{r_target[31]}}, r_target} - {{2{r_pos[31]}}, r_pos};
            end
            mprc_pkg::SEQ_EVAL: begin
                case (r_mode)
                    mprc_pkg::MODE_STOP: begin
                        n_duty = 16'd0;
                        if (w_go_fwd) n_mode = mprc_pkg::MODE_FWD;
                    end
                    mprc_pkg::MODE_FWD: begin
                        n_dir = 1'b1;
                        if (w_halt) n_mode = mprc_pkg::MODE_STOP;
                        n_lim = w_dist_lt_span ? r_dist[15:0] : w_span;
                    end
                    default: begin
                        n_mode = mprc_pkg::MODE_ERROR;
                        n_duty = 16'd0;
                    end
                endcase
            end
            mprc_pkg::SEQ_MUL: begin
                w_div_req.start = 1'b1;
                w_div_req.num   = 32'({16'h0000, FullDuty} * {16'h0000, r_lim});
            end
            mprc_pkg::SEQ_DIV: begin
                if (w_div_done) begin
                    n_duty = (w_duty_sum > {1'b0, FullDuty}) ? FullDuty : w_duty_sum[15:0];
                end
            end
            mprc_pkg::SEQ_FIN: begin
                if (w_out_free) begin
                    n_out_valid    = 1'b1;
                    n_out.duty     = r_duty;
                    n_out.direction = r_dir;
                    n_out.mode     = r_mode;
                    n_out.position = r_pos;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mprc_pkg::SEQ_IDLE;
            r_mode      <= mprc_pkg::MODE_STOP;
            r_wrap      <= 16'd0;
            r_target    <= 32'd0;
            r_duty      <= 16'd0;
            r_dir       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_wrap      <= n_wrap;
            r_target    <= n_target;
            r_duty      <= n_duty;
            r_dir       <= n_dir;
            r_out_valid <= n_out_valid;
        end
        if (w_in_acc) r_in <= i_in_data;
        r_pos  <= n_pos;
        r_dist <= n_dist;
        r_lim  <= n_lim;
        r_out  <= n_out;
    end

    mprc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    property p_error_sticky;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_mode == mprc_pkg::MODE_ERROR) |=> (r_mode == mprc_pkg::MODE_ERROR);
    endproperty
    a_error_sticky: assert property (p_error_sticky)
        else $error("error mode was left without reset");

    property p_error_zero_duty;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_mode == mprc_pkg::MODE_ERROR) |-> (r_duty == 16'd0);
    endproperty
    a_error_zero_duty: assert property (p_error_zero_duty)
        else $error("nonzero duty in error mode");

    property p_duty_capped;
        @(posedge i_clk) disable iff (!i_rst_n) r_duty <= FullDuty;
    endproperty
    a_duty_capped: assert property (p_duty_capped)
        else $error("duty above full scale");

    property p_div_done_in_div;
        @(posedge i_clk) disable iff (!i_rst_n)
            w_div_done |-> (r_state == mprc_pkg::SEQ_DIV);
    endproperty
    a_div_done_in_div: assert property (p_div_done_in_div)
        else $error("divider finished outside its sequencer step");

endmodule

`default_nettype wire
